[hdl/ljg_pkg.sv]
// shared widths, constants and request structs of the lennard-jones gradient block
// no dependencies; every other file refers to it by scoped names
package ljg_pkg;

    // cluster size and index widths
    localparam int MAX_ATOMS = 64;
    localparam int IDX_W     = 6;
    localparam int CNT_W     = 7;

    // datapath widths
    localparam int COORD_W   = 32;
    localparam int DIFF_W    = 33;
    localparam int SQ_W      = 48;
    localparam int DSQ_W     = 50;
    localparam int QUO_W     = 49;
    localparam int REM_W     = 51;
    localparam int POW_W     = 57;
    localparam int FMAG_W    = 62;
    localparam int GRAD_W    = 48;
    localparam int DIV_CELLS = QUO_W;

    // constants
    localparam logic [COORD_W-1:0]       MIN_DSQ_RESET = 32'd32768;
    localparam logic [POW_W-1:0]         POW_CAP       = {1'b1, 56'd0};
    localparam logic signed [GRAD_W-1:0] TERM_CAP      = {1'b0, {47{1'b1}}};
    localparam logic signed [GRAD_W-1:0] ACC_MAX       = {1'b0, {47{1'b1}}};
    localparam logic signed [GRAD_W-1:0] ACC_MIN       = {1'b1, 47'd0};

    // sideband that travels with one pair through the pipeline
    typedef struct packed {
        logic                     valid;
        logic [IDX_W-1:0]         j;
        logic                     flag;
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dy;
        logic signed [DIFF_W-1:0] dz;
    } ljg_side_t;

    // state handed from one divider cell to the next
    typedef struct packed {
        ljg_side_t          side;
        logic [DSQ_W-1:0]   den;
        logic [REM_W-1:0]   rem;
        logic [QUO_W-1:0]   quo;
    } ljg_div_t;

    // finished pair term
    typedef struct packed {
        logic                     valid;
        logic [IDX_W-1:0]         j;
        logic                     flag;
        logic signed [GRAD_W-1:0] tx;
        logic signed [GRAD_W-1:0] ty;
        logic signed [GRAD_W-1:0] tz;
    } ljg_term_t;

    // one atom's gradient row
    typedef struct packed {
        logic                     sat;
        logic signed [GRAD_W-1:0] gx;
        logic signed [GRAD_W-1:0] gy;
        logic signed [GRAD_W-1:0] gz;
    } ljg_grow_t;

endpackage

[hdl/ljg_div_cell.sv]
// one cell of the reciprocal divider chain: one quotient bit per cell
// depends on ljg_pkg
module ljg_div_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              num_bit,
    input  ljg_pkg::ljg_div_t din,
    output ljg_pkg::ljg_div_t dout
);

    logic [ljg_pkg::REM_W-1:0] trial;
    logic [ljg_pkg::REM_W-1:0] den_ext;
    logic                      ge;
    ljg_pkg::ljg_div_t         cell_next;
    ljg_pkg::ljg_div_t         cell_reg;

    // shift in the next numerator bit, subtract when it fits
    always_comb
    begin
        trial     = {din.rem[ljg_pkg::REM_W-2:0], num_bit};
        den_ext   = {1'b0, din.den};
        ge        = (trial >= den_ext);
        cell_next = din;
        cell_next.rem = ge ? (trial - den_ext) : trial;
        cell_next.quo = {din.quo[ljg_pkg::QUO_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_reg.side.valid <= 1'b0;
        end
        else
        begin
            cell_reg <= cell_next;
        end
    end

    assign dout = cell_reg;

endmodule

[hdl/ljg_mul_sat.sv]
// two-stage floor(a*b / 2^32) with saturation at 2^56, built from 32-bit partial products
// depends on ljg_pkg
module ljg_mul_sat (
    input  logic                      clk,
    input  logic [ljg_pkg::POW_W-1:0] a,
    input  logic [ljg_pkg::POW_W-1:0] b,
    output logic [ljg_pkg::POW_W-1:0] prod,
    output logic                      ovf
);

    logic [63:0] p00_reg;
    logic [56:0] p01_reg;
    logic [56:0] p10_reg;
    logic [49:0] p11_reg;
    logic [83:0] sum;
    logic        ovf_next;
    logic [ljg_pkg::POW_W-1:0] prod_next;
    logic [ljg_pkg::POW_W-1:0] prod_reg;
    logic        ovf_reg;

    // partial products
    always_ff @(posedge clk)
    begin
        p00_reg <= a[31:0] * b[31:0];
        p01_reg <= a[31:0] * b[56:32];
        p10_reg <= a[56:32] * b[31:0];
        p11_reg <= a[56:32] * b[56:32];
    end

    // recombine, drop the low word, saturate
    always_comb
    begin
        sum = (84'(p11_reg) << 32) + 84'(p01_reg) + 84'(p10_reg) + 84'(p00_reg[63:32]);
        ovf_next  = (sum > 84'(ljg_pkg::POW_CAP));
        prod_next = ovf_next ? ljg_pkg::POW_CAP : sum[ljg_pkg::POW_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        ovf_reg  <= ovf_next;
    end

    assign prod = prod_reg;
    assign ovf  = ovf_reg;

endmodule

[hdl/ljg_pair_unit.sv]
// pipelined pair unit: distance, clamp, divider chain, powers, force terms
// depends on ljg_pkg, ljg_div_cell, ljg_mul_sat
module ljg_pair_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    input  logic [ljg_pkg::IDX_W-1:0]           req_j,
    input  logic signed [ljg_pkg::COORD_W-1:0]  pi_x,
    input  logic signed [ljg_pkg::COORD_W-1:0]  pi_y,
    input  logic signed [ljg_pkg::COORD_W-1:0]  pi_z,
    input  logic signed [ljg_pkg::COORD_W-1:0]  pj_x,
    input  logic signed [ljg_pkg::COORD_W-1:0]  pj_y,
    input  logic signed [ljg_pkg::COORD_W-1:0]  pj_z,
    input  logic [ljg_pkg::COORD_W-1:0]         lim,
    output ljg_pkg::ljg_term_t                  term
);

    function automatic logic [31:0] mag33(input logic signed [ljg_pkg::DIFF_W-1:0] v);
        logic [ljg_pkg::DIFF_W-1:0] n;
        n = v[ljg_pkg::DIFF_W-1] ? -v : v;
        return n[31:0];
    endfunction

    ljg_pkg::ljg_side_t s1_reg, s2_reg;
    logic [ljg_pkg::SQ_W-1:0] sqx_reg, sqy_reg, sqz_reg;
    logic [63:0] px, py, pz;
    logic [ljg_pkg::DSQ_W-1:0] dsum, limit;
    ljg_pkg::ljg_div_t div_next, div_reg;
    ljg_pkg::ljg_div_t chain [ljg_pkg::DIV_CELLS+1];
    logic [ljg_pkg::POW_W-1:0] q;
    logic [ljg_pkg::POW_W-1:0] qa1_reg, qa2_reg, p4c1_reg, p4c2_reg;
    logic [ljg_pkg::POW_W-1:0] p2, p3, p4, p7;
    logic ovf1, ovf2, ovf3, ovf4;
    ljg_pkg::ljg_side_t sa1_reg, sa2_reg, sb1_reg, sb2_reg, sc1_reg, sc2_reg, sf_reg, st_reg;
    logic signed [63:0] f;
    logic [63:0] fabs;
    logic [ljg_pkg::FMAG_W-1:0] fmag_reg;
    logic fneg_reg;
    logic [63:0] lox_reg, loy_reg, loz_reg;
    logic [61:0] hix_reg, hiy_reg, hiz_reg;
    logic negx_reg, negy_reg, negz_reg;
    logic [63:0] mx, my, mz;
    logic satx, saty, satz;
    logic signed [ljg_pkg::GRAD_W-1:0] cx, cy, cz;
    ljg_pkg::ljg_term_t term_next, term_reg;

    // squares of the axis differences
    always_comb
    begin
        px = mag33(s1_reg.dx) * mag33(s1_reg.dx);
        py = mag33(s1_reg.dy) * mag33(s1_reg.dy);
        pz = mag33(s1_reg.dz) * mag33(s1_reg.dz);
    end

    // squared distance, clamp to the minimum
    always_comb
    begin
        dsum  = ljg_pkg::DSQ_W'(sqx_reg) + ljg_pkg::DSQ_W'(sqy_reg)
              + ljg_pkg::DSQ_W'(sqz_reg);
        limit = (lim == '0) ? ljg_pkg::DSQ_W'(1) : ljg_pkg::DSQ_W'(lim);
        div_next.side = s2_reg;
        div_next.den  = dsum;
        if (dsum < limit)
        begin
            div_next.den       = limit;
            div_next.side.flag = 1'b1;
        end
        div_next.rem = '0;
        div_next.quo = '0;
    end

    // divider chain for 2^48 / d2
    assign chain[0] = div_reg;
    for (genvar c = 0; c < ljg_pkg::DIV_CELLS; c++)
    begin : g_div
        ljg_div_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .num_bit ((c == 0) ? 1'b1 : 1'b0),
            .din     (chain[c]),
            .dout    (chain[c+1])
        );
    end
    assign q = ljg_pkg::POW_W'(chain[ljg_pkg::DIV_CELLS].quo);

    // power ladder
    ljg_mul_sat u_p2 (.clk(clk), .a(q),        .b(q),        .prod(p2), .ovf(ovf1));
    ljg_mul_sat u_p3 (.clk(clk), .a(p2),       .b(qa2_reg),  .prod(p3), .ovf(ovf2));
    ljg_mul_sat u_p4 (.clk(clk), .a(p2),       .b(p2),       .prod(p4), .ovf(ovf3));
    ljg_mul_sat u_p7 (.clk(clk), .a(p4),       .b(p3),       .prod(p7), .ovf(ovf4));

    // force factor 24*p4 - 48*p7
    always_comb
    begin
        f = $signed((64'(p4c2_reg) << 4) + (64'(p4c2_reg) << 3))
          - $signed((64'(p7) << 5) + (64'(p7) << 4));
        fabs = f[63] ? 64'(-f) : 64'(f);
    end

    // terms per axis, saturated
    always_comb
    begin
        mx = 64'(hix_reg) + 64'(lox_reg[63:32]);
        my = 64'(hiy_reg) + 64'(loy_reg[63:32]);
        mz = 64'(hiz_reg) + 64'(loz_reg[63:32]);
        satx = (mx > 64'(ljg_pkg::TERM_CAP));
        saty = (my > 64'(ljg_pkg::TERM_CAP));
        satz = (mz > 64'(ljg_pkg::TERM_CAP));
        cx = satx ? ljg_pkg::TERM_CAP : $signed(mx[ljg_pkg::GRAD_W-1:0]);
        cy = saty ? ljg_pkg::TERM_CAP : $signed(my[ljg_pkg::GRAD_W-1:0]);
        cz = satz ? ljg_pkg::TERM_CAP : $signed(mz[ljg_pkg::GRAD_W-1:0]);
        term_next.valid = st_reg.valid;
        term_next.j     = st_reg.j;
        term_next.flag  = st_reg.flag | satx | saty | satz;
        term_next.tx    = negx_reg ? -cx : cx;
        term_next.ty    = negy_reg ? -cy : cy;
        term_next.tz    = negz_reg ? -cz : cz;
    end

    // pipeline registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg.valid      <= 1'b0;
            s2_reg.valid      <= 1'b0;
            div_reg.side.valid <= 1'b0;
            sa1_reg.valid     <= 1'b0;
            sa2_reg.valid     <= 1'b0;
            sb1_reg.valid     <= 1'b0;
            sb2_reg.valid     <= 1'b0;
            sc1_reg.valid     <= 1'b0;
            sc2_reg.valid     <= 1'b0;
            sf_reg.valid      <= 1'b0;
            st_reg.valid      <= 1'b0;
            term_reg.valid    <= 1'b0;
        end
        else
        begin
            s1_reg.valid <= req_valid;
            s1_reg.j     <= req_j;
            s1_reg.flag  <= 1'b0;
            s1_reg.dx    <= ljg_pkg::DIFF_W'(pi_x) - ljg_pkg::DIFF_W'(pj_x);
            s1_reg.dy    <= ljg_pkg::DIFF_W'(pi_y) - ljg_pkg::DIFF_W'(pj_y);
            s1_reg.dz    <= ljg_pkg::DIFF_W'(pi_z) - ljg_pkg::DIFF_W'(pj_z);
            s2_reg       <= s1_reg;
            sqx_reg      <= px[63:16];
            sqy_reg      <= py[63:16];
            sqz_reg      <= pz[63:16];
            div_reg      <= div_next;
            sa1_reg      <= chain[ljg_pkg::DIV_CELLS].side;
            sa2_reg      <= sa1_reg;
            qa1_reg      <= q;
            qa2_reg      <= qa1_reg;
            sb1_reg      <= sa2_reg;
            sb1_reg.flag <= sa2_reg.flag | ovf1;
            sb2_reg      <= sb1_reg;
            sc1_reg      <= sb2_reg;
            sc1_reg.flag <= sb2_reg.flag | ovf2 | ovf3;
            sc2_reg      <= sc1_reg;
            p4c1_reg     <= p4;
            p4c2_reg     <= p4c1_reg;
            sf_reg       <= sc2_reg;
            sf_reg.flag  <= sc2_reg.flag | ovf4;
            fmag_reg     <= fabs[ljg_pkg::FMAG_W-1:0];
            fneg_reg     <= f[63];
            st_reg       <= sf_reg;
            lox_reg      <= fmag_reg[31:0] * mag33(sf_reg.dx);
            loy_reg      <= fmag_reg[31:0] * mag33(sf_reg.dy);
            loz_reg      <= fmag_reg[31:0] * mag33(sf_reg.dz);
            hix_reg      <= fmag_reg[61:32] * mag33(sf_reg.dx);
            hiy_reg      <= fmag_reg[61:32] * mag33(sf_reg.dy);
            hiz_reg      <= fmag_reg[61:32] * mag33(sf_reg.dz);
            negx_reg     <= fneg_reg ^ sf_reg.dx[ljg_pkg::DIFF_W-1];
            negy_reg     <= fneg_reg ^ sf_reg.dy[ljg_pkg::DIFF_W-1];
            negz_reg     <= fneg_reg ^ sf_reg.dz[ljg_pkg::DIFF_W-1];
            term_reg     <= term_next;
        end
    end

    assign term = term_reg;

endmodule

[hdl/lennard_jones_gradient.sv]
// top level: atom store, gradient store, row sequencer and result register
// depends on ljg_pkg, ljg_pair_unit (ljg_div_cell, ljg_mul_sat below it)
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------
//  in      | in_valid / in_stall  | coord_x, coord_y, coord_z, last_atom
//  out     | out_valid / out_stall| atom_index, grad_x/y/z, saturated, last_result
//  cfg     | cfg_valid / cfg_ready| cfg_data (min_dist_sq)
//
// loading accepts one atom per cycle; the request with last_atom starts the run.
// each row i issues its (N-1-i) pairs, then waits in ST_DRAIN until the pair pipeline
// (49 divider cells) has drained; each result is read in ST_OUT_RD, loaded in ST_OUT_LD.
// reset clears control only; the gradient store is cleared by 64 valid bits per run.
// inputs stall during compute and output; a waiting result does not block loading.
module lennard_jones_gradient (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [ljg_pkg::COORD_W-1:0]  coord_x,
    input  logic signed [ljg_pkg::COORD_W-1:0]  coord_y,
    input  logic signed [ljg_pkg::COORD_W-1:0]  coord_z,
    input  logic                                last_atom,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [ljg_pkg::IDX_W-1:0]           atom_index,
    output logic signed [ljg_pkg::GRAD_W-1:0]   grad_x,
    output logic signed [ljg_pkg::GRAD_W-1:0]   grad_y,
    output logic signed [ljg_pkg::GRAD_W-1:0]   grad_z,
    output logic                                saturated,
    output logic                                last_result,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ljg_pkg::COORD_W-1:0]         cfg_data
);

    localparam logic [3:0] ST_LOAD   = 4'd0;
    localparam logic [3:0] ST_START  = 4'd1;
    localparam logic [3:0] ST_ROW_RD = 4'd2;
    localparam logic [3:0] ST_ROW_LD = 4'd3;
    localparam logic [3:0] ST_ISSUE  = 4'd4;
    localparam logic [3:0] ST_DRAIN  = 4'd5;
    localparam logic [3:0] ST_WB     = 4'd6;
    localparam logic [3:0] ST_OUT_RD = 4'd7;
    localparam logic [3:0] ST_OUT_LD = 4'd8;

    function automatic logic [ljg_pkg::GRAD_W:0] sat_add(
        input logic signed [ljg_pkg::GRAD_W-1:0] a,
        input logic signed [ljg_pkg::GRAD_W-1:0] b
    );
        logic signed [ljg_pkg::GRAD_W:0] s;
        logic [ljg_pkg::GRAD_W:0] r;
        s = (ljg_pkg::GRAD_W+1)'(a) + (ljg_pkg::GRAD_W+1)'(b);
        if (s > (ljg_pkg::GRAD_W+1)'(ljg_pkg::ACC_MAX))
            r = {1'b1, ljg_pkg::ACC_MAX};
        else if (s < (ljg_pkg::GRAD_W+1)'(ljg_pkg::ACC_MIN))
            r = {1'b1, ljg_pkg::ACC_MIN};
        else
            r = {1'b0, s[ljg_pkg::GRAD_W-1:0]};
        return r;
    endfunction

    logic [3:0] state_reg, state_next;
    logic [ljg_pkg::CNT_W-1:0] count_reg, count_next, n_reg, n_next;
    logic [ljg_pkg::CNT_W-1:0] inflight_reg, inflight_next;
    logic [ljg_pkg::IDX_W-1:0] i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic signed [ljg_pkg::COORD_W-1:0] pix_reg, piy_reg, piz_reg;
    logic signed [ljg_pkg::COORD_W-1:0] pix_next, piy_next, piz_next;
    ljg_pkg::ljg_grow_t acc_reg, acc_next;
    logic iss_valid_reg, iss_valid_next;
    logic [ljg_pkg::IDX_W-1:0] iss_j_reg, iss_j_next;
    logic wr_valid_reg;
    logic [ljg_pkg::IDX_W-1:0] wr_j_reg;
    logic wr_flag_reg;
    logic signed [ljg_pkg::GRAD_W-1:0] wr_tx_reg, wr_ty_reg, wr_tz_reg;
    logic [ljg_pkg::MAX_ATOMS-1:0] gvalid_reg, gvalid_next;
    logic out_valid_reg, out_valid_next, out_last_reg, out_last_next;
    logic [ljg_pkg::IDX_W-1:0] out_index_reg, out_index_next;
    ljg_pkg::ljg_grow_t out_row_reg, out_row_next;
    logic [ljg_pkg::COORD_W-1:0] min_dsq_reg, min_dsq_next;

    logic [3*ljg_pkg::COORD_W-1:0] pos_mem_reg [ljg_pkg::MAX_ATOMS];
    logic [3*ljg_pkg::COORD_W-1:0] pos_rd_reg;
    ljg_pkg::ljg_grow_t grad_mem_reg [ljg_pkg::MAX_ATOMS];
    ljg_pkg::ljg_grow_t grad_rd_reg, grad_base, grad_wdata, wr_row;
    logic grad_rdv_reg;
    logic pos_we, grad_we, issue_now;
    logic [ljg_pkg::IDX_W-1:0] pos_raddr, grad_raddr, grad_waddr;
    logic in_accept, out_take, last_j, next_row;
    logic [ljg_pkg::GRAD_W:0] ax, ay, az, bx, by, bz;
    ljg_pkg::ljg_term_t term;

    assign in_stall  = (state_reg != ST_LOAD);
    assign in_accept = in_valid && !in_stall;
    assign out_take  = out_valid_reg && !out_stall;
    assign cfg_ready = 1'b1;
    assign last_j    = ({1'b0, j_reg} == (n_reg - ljg_pkg::CNT_W'(1)));
    assign next_row  = (({1'b0, i_reg} + ljg_pkg::CNT_W'(2)) < n_reg);
    assign issue_now = (state_reg == ST_ISSUE);

    // pair pipeline
    ljg_pair_unit u_pair (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (iss_valid_reg),
        .req_j     (iss_j_reg),
        .pi_x      (pix_reg),
        .pi_y      (piy_reg),
        .pi_z      (piz_reg),
        .pj_x      ($signed(pos_rd_reg[31:0])),
        .pj_y      ($signed(pos_rd_reg[63:32])),
        .pj_z      ($signed(pos_rd_reg[95:64])),
        .lim       (min_dsq_reg),
        .term      (term)
    );

    // row i side of the term and row j side read-modify-write
    always_comb
    begin
        ax = sat_add(acc_reg.gx, term.tx);
        ay = sat_add(acc_reg.gy, term.ty);
        az = sat_add(acc_reg.gz, term.tz);
        grad_base = grad_rdv_reg ? grad_rd_reg : '0;
        bx = sat_add(grad_base.gx, -wr_tx_reg);
        by = sat_add(grad_base.gy, -wr_ty_reg);
        bz = sat_add(grad_base.gz, -wr_tz_reg);
        wr_row.gx  = bx[ljg_pkg::GRAD_W-1:0];
        wr_row.gy  = by[ljg_pkg::GRAD_W-1:0];
        wr_row.gz  = bz[ljg_pkg::GRAD_W-1:0];
        wr_row.sat = grad_base.sat | wr_flag_reg | bx[ljg_pkg::GRAD_W]
                   | by[ljg_pkg::GRAD_W] | bz[ljg_pkg::GRAD_W];
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        n_next         = n_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        pix_next       = pix_reg;
        piy_next       = piy_reg;
        piz_next       = piz_reg;
        acc_next       = acc_reg;
        iss_valid_next = 1'b0;
        iss_j_next     = j_reg;
        gvalid_next    = gvalid_reg;
        out_valid_next = out_valid_reg && !out_take;
        out_index_next = out_index_reg;
        out_row_next   = out_row_reg;
        out_last_next  = out_last_reg;
        min_dsq_next   = cfg_valid ? cfg_data : min_dsq_reg;
        pos_we         = 1'b0;
        pos_raddr      = j_reg;
        grad_raddr     = term.j;
        grad_we        = 1'b0;
        grad_waddr     = wr_j_reg;
        grad_wdata     = wr_row;
        inflight_next  = inflight_reg + ljg_pkg::CNT_W'(issue_now)
                       - ljg_pkg::CNT_W'(wr_valid_reg);

        if (term.valid)
        begin
            acc_next.gx  = ax[ljg_pkg::GRAD_W-1:0];
            acc_next.gy  = ay[ljg_pkg::GRAD_W-1:0];
            acc_next.gz  = az[ljg_pkg::GRAD_W-1:0];
            acc_next.sat = acc_reg.sat | term.flag | ax[ljg_pkg::GRAD_W]
                         | ay[ljg_pkg::GRAD_W] | az[ljg_pkg::GRAD_W];
        end
        if (wr_valid_reg)
        begin
            grad_we = 1'b1;
            gvalid_next[wr_j_reg] = 1'b1;
        end

        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_accept)
                begin
                    if (count_reg < ljg_pkg::CNT_W'(ljg_pkg::MAX_ATOMS))
                    begin
                        pos_we     = 1'b1;
                        count_next = count_reg + ljg_pkg::CNT_W'(1);
                    end
                    if (last_atom)
                    begin
                        n_next     = count_next;
                        state_next = ST_START;
                    end
                end
            end
            ST_START:
            begin
                gvalid_next = '0;
                i_next      = '0;
                k_next      = '0;
                state_next  = (n_reg == ljg_pkg::CNT_W'(1)) ? ST_OUT_RD : ST_ROW_RD;
            end
            ST_ROW_RD:
            begin
                pos_raddr  = i_reg;
                grad_raddr = i_reg;
                state_next = ST_ROW_LD;
            end
            ST_ROW_LD:
            begin
                pix_next   = $signed(pos_rd_reg[31:0]);
                piy_next   = $signed(pos_rd_reg[63:32]);
                piz_next   = $signed(pos_rd_reg[95:64]);
                acc_next   = grad_rdv_reg ? grad_rd_reg : '0;
                j_next     = i_reg + ljg_pkg::IDX_W'(1);
                state_next = ST_ISSUE;
            end
            ST_ISSUE:
            begin
                iss_valid_next = 1'b1;
                if (last_j)
                    state_next = ST_DRAIN;
                else
                    j_next = j_reg + ljg_pkg::IDX_W'(1);
            end
            ST_DRAIN:
            begin
                if (inflight_reg == '0)
                    state_next = ST_WB;
            end
            ST_WB:
            begin
                grad_we            = 1'b1;
                grad_waddr         = i_reg;
                grad_wdata         = acc_reg;
                gvalid_next[i_reg] = 1'b1;
                i_next             = i_reg + ljg_pkg::IDX_W'(1);
                state_next         = next_row ? ST_ROW_RD : ST_OUT_RD;
            end
            ST_OUT_RD:
            begin
                grad_raddr = k_reg;
                if (!out_valid_reg || out_take)
                    state_next = ST_OUT_LD;
            end
            ST_OUT_LD:
            begin
                grad_raddr     = k_reg;
                out_valid_next = 1'b1;
                out_index_next = k_reg;
                out_row_next   = grad_rdv_reg ? grad_rd_reg : '0;
                out_last_next  = ({1'b0, k_reg} == (n_reg - ljg_pkg::CNT_W'(1)));
                if (out_last_next)
                begin
                    count_next = '0;
                    state_next = ST_LOAD;
                end
                else
                begin
                    k_next     = k_reg + ljg_pkg::IDX_W'(1);
                    state_next = ST_OUT_RD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // control and payload registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            n_reg         <= '0;
            inflight_reg  <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            iss_valid_reg <= 1'b0;
            wr_valid_reg  <= 1'b0;
            gvalid_reg    <= '0;
            out_valid_reg <= 1'b0;
            min_dsq_reg   <= ljg_pkg::MIN_DSQ_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            n_reg         <= n_next;
            inflight_reg  <= inflight_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            iss_valid_reg <= iss_valid_next;
            wr_valid_reg  <= term.valid;
            gvalid_reg    <= gvalid_next;
            out_valid_reg <= out_valid_next;
            min_dsq_reg   <= min_dsq_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pix_reg       <= pix_next;
        piy_reg       <= piy_next;
        piz_reg       <= piz_next;
        acc_reg       <= acc_next;
        iss_j_reg     <= iss_j_next;
        wr_j_reg      <= term.j;
        wr_flag_reg   <= term.flag;
        wr_tx_reg     <= term.tx;
        wr_ty_reg     <= term.ty;
        wr_tz_reg     <= term.tz;
        out_index_reg <= out_index_next;
        out_row_reg   <= out_row_next;
        out_last_reg  <= out_last_next;
    end

    // atom position store
    always_ff @(posedge clk)
    begin
        if (pos_we)
            pos_mem_reg[count_reg[ljg_pkg::IDX_W-1:0]] <= {coord_z, coord_y, coord_x};
        pos_rd_reg <= pos_mem_reg[pos_raddr];
    end

    // gradient store
    always_ff @(posedge clk)
    begin
        if (grad_we)
            grad_mem_reg[grad_waddr] <= grad_wdata;
        grad_rd_reg  <= grad_mem_reg[grad_raddr];
        grad_rdv_reg <= gvalid_reg[grad_raddr];
    end

    assign out_valid   = out_valid_reg;
    assign atom_index  = out_index_reg;
    assign grad_x      = out_row_reg.gx;
    assign grad_y      = out_row_reg.gy;
    assign grad_z      = out_row_reg.gz;
    assign saturated   = out_row_reg.sat;
    assign last_result = out_last_reg;

`ifndef SYNTH
    // a new row only starts once every pair of the previous row is written back
    a_row_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROW_RD) |-> (inflight_reg == '0))
        else $error("row started with pairs in flight");

    // write-backs of the j side always target a later atom than row i
    a_wr_order: assert property (@(posedge clk) disable iff (!rst_n)
        wr_valid_reg |-> (wr_j_reg > i_reg))
        else $error("pair write-back to a row at or before i");

    // loading only while the pair pipeline is empty
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |-> (inflight_reg == '0 && !term.valid && !wr_valid_reg))
        else $error("requests taken while pairs in flight");
`endif

endmodule
